[hdl/range_select_compress_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the range select and compress unit
// Short forms of the concurrent assertions that its checker uses.
// ----------------------------------------------------------------------------
`ifndef RANGE_SELECT_COMPRESS_UNIT_MACROS_SVH
`define RANGE_SELECT_COMPRESS_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RSC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("range select compress: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("range select compress: assertion failed");

// No disable clause, for properties about reset itself.
`define RSC_ASSERT_RAW(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("range select compress: reset assertion failed");

`endif

[hdl/rsc_pkg.sv]
// ----------------------------------------------------------------------------
// Range select and compress package
// Widths, register codes, reset values and shared types of the block.
// ----------------------------------------------------------------------------
package rsc_pkg;

    localparam int unsigned VALUE_W    = 64;
    localparam int unsigned POS_W      = 32;
    localparam int unsigned BOUND_W    = 32;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned OUT_DATA_W = VALUE_W + POS_W;

    localparam logic [BOUND_W-1:0] LOWER_RESET = 32'd5000;
    localparam logic [BOUND_W-1:0] UPPER_RESET = 32'd10000;

    // Register select, taken from the word address bit of paddr.
    typedef enum logic {
        REG_LOWER = 1'b0,
        REG_UPPER = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [BOUND_W-1:0] lower;
        logic [BOUND_W-1:0] upper;
    } t_bounds;

    typedef struct packed {
        logic [POS_W-1:0]   position;
        logic [VALUE_W-1:0] value;
        logic               last;
    } t_beat;

endpackage

[hdl/rsc_lane.sv]
// ----------------------------------------------------------------------------
// Range select lane
// Tests one 64-bit value against the exclusive 32-bit bounds.
// ----------------------------------------------------------------------------
module rsc_lane (
    input  logic [rsc_pkg::VALUE_W-1:0] i_value,
    input  rsc_pkg::t_bounds            i_bounds,
    output logic                        o_hit
);

    logic high_zero;
    logic above_lower;
    logic below_upper;

    // The bounds are 32 bits, so any set upper half puts the value above both.
    assign high_zero   = (i_value[rsc_pkg::VALUE_W-1:rsc_pkg::BOUND_W] == '0);
    assign above_lower = !high_zero || (i_value[rsc_pkg::BOUND_W-1:0] > i_bounds.lower);
    assign below_upper = high_zero && (i_value[rsc_pkg::BOUND_W-1:0] < i_bounds.upper);
    assign o_hit       = above_lower && below_upper;

endmodule

[hdl/rsc_merge.sv]
// ----------------------------------------------------------------------------
// Range select merge stage
// Holds one group with its hit mask and sends the hits out in lane order,
// one per cycle while the output register is free, with a running output position.
// ----------------------------------------------------------------------------
module rsc_merge #(
    parameter int unsigned LANES = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [LANES-1:0][rsc_pkg::VALUE_W-1:0] i_values,
    input  logic [LANES-1:0]                    i_hits,
    input  logic                                i_restart,
    output logic                                o_valid,
    input  logic                                i_ready,
    output rsc_pkg::t_beat                      o_beat
);

    localparam int unsigned IDX_W = $clog2(LANES);

    logic                                  r_grp_valid, n_grp_valid;
    logic [LANES-1:0][rsc_pkg::VALUE_W-1:0] r_values, n_values;
    logic [LANES-1:0]                      r_mask, n_mask;
    logic [rsc_pkg::POS_W-1:0]             r_pos, n_pos;
    logic                                  r_out_valid, n_out_valid;
    rsc_pkg::t_beat                        r_out, n_out;

    logic [IDX_W-1:0] pick_idx;
    logic [LANES-1:0] remaining;
    logic             out_free;
    logic             pick;
    logic             grp_done;
    logic             load;

    // Lowest set bit of the mask is the next hit to leave.
    always_comb begin
        pick_idx = '0;
        for (int i = LANES - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                pick_idx = IDX_W'(i);
            end
        end
    end

    assign remaining = r_mask & ~(LANES'(1) << pick_idx);
    assign out_free  = !r_out_valid || i_ready;
    assign pick      = r_grp_valid && (r_mask != '0) && out_free;
    // A group without hits is done without waiting for the output and gives no beat.
    assign grp_done  = r_grp_valid && ((r_mask == '0) || (pick && (remaining == '0)));
    assign o_ready   = !r_grp_valid || grp_done;
    assign load      = i_valid && o_ready;

    always_comb begin
        n_grp_valid = r_grp_valid;
        n_values    = r_values;
        n_mask      = r_mask;
        n_pos       = r_pos;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (i_ready) begin
            n_out_valid = 1'b0;
        end
        if (pick) begin
            n_out_valid    = 1'b1;
            n_out.value    = r_values[pick_idx];
            n_out.position = r_pos;
            n_out.last     = (remaining == '0);
            n_mask         = remaining;
            n_pos          = r_pos + 1'b1;
        end
        if (grp_done) begin
            n_grp_valid = 1'b0;
        end
        // The last beat of the old group has already taken r_pos above.
        if (load) begin
            n_grp_valid = 1'b1;
            n_values    = i_values;
            n_mask      = i_hits;
            if (i_restart) begin
                n_pos = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp_valid <= 1'b0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_grp_valid <= n_grp_valid;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_values <= n_values;
        r_mask   <= n_mask;
        r_out    <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_beat  = r_out;

endmodule

[hdl/range_select_compress_unit.sv]
// ----------------------------------------------------------------------------
// Range select and compress unit
// Keeps the values of each group that lie strictly between two bounds and
// streams them out, compacted, with their output positions.
// ----------------------------------------------------------------------------
// A group of LANES 64-bit values arrives as one slave beat, lane 0 in the
// lowest bits, with the restart flag in tuser. Every lane compares its value
// with the bounds in parallel as the beat is taken. The merge stage then
// sends each hit as one master beat in lane order: the value, its position
// in the compacted stream (wrapping at 32 bits) and tlast on the final hit
// of the group. A group without hits produces no beat.
// The first beat of a group passes through the merge stage's group register
// and then its output register.
// The merge stage sends one hit of a group per cycle while the receiver
// does not stall; the output register holds one beat at a time. The next
// group is taken in the cycle that the current one sends its last hit.
// If the receiver stalls, the output register holds its beat, the merge
// stage waits and tready on the slave side falls once the group is held.
// Reset clears the position to zero and the bounds to 5000 and 10000.
// The bounds are written over the APB port at byte addresses 0 and 4.
// ----------------------------------------------------------------------------
module range_select_compress_unit #(
    parameter int unsigned LANES = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // APB configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rsc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [rsc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [rsc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    // Slave side
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // Fields from bit 0: lane_0, lane_1, ... lane_(LANES-1), 64 bits each.
    input  logic [LANES*rsc_pkg::VALUE_W-1:0]  s_axis_tdata,
    // Fields from bit 0: restart.
    input  logic [0:0]                         s_axis_tuser,
    // Master side
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // Fields from bit 0: kept_value (64 bits), out_position (32 bits).
    output logic [rsc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic                               m_axis_tlast
);

    logic [rsc_pkg::BOUND_W-1:0]            r_lower, n_lower;
    logic [rsc_pkg::BOUND_W-1:0]            r_upper, n_upper;
    rsc_pkg::t_bounds                       bounds;
    rsc_pkg::t_reg_idx                      reg_sel;
    logic                                   cfg_write;
    logic [LANES-1:0]                       hits;
    logic [LANES-1:0][rsc_pkg::VALUE_W-1:0] values;
    rsc_pkg::t_beat                         beat;

    // Word-aligned registers: the byte offset bits are not decoded.
    assign reg_sel   = rsc_pkg::t_reg_idx'(paddr[2]);
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_comb begin
        n_lower = r_lower;
        n_upper = r_upper;
        if (cfg_write) begin
            case (reg_sel)
                rsc_pkg::REG_LOWER: n_lower = pwdata;
                rsc_pkg::REG_UPPER: n_upper = pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            rsc_pkg::REG_LOWER: prdata = r_lower;
            rsc_pkg::REG_UPPER: prdata = r_upper;
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower <= rsc_pkg::LOWER_RESET;
            r_upper <= rsc_pkg::UPPER_RESET;
        end else begin
            r_lower <= n_lower;
            r_upper <= n_upper;
        end
    end

    assign bounds.lower = r_lower;
    assign bounds.upper = r_upper;

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        assign values[g] = s_axis_tdata[g*rsc_pkg::VALUE_W +: rsc_pkg::VALUE_W];

        rsc_lane u_lane (
            .i_value  (values[g]),
            .i_bounds (bounds),
            .o_hit    (hits[g])
        );
    end

    rsc_merge #(
        .LANES (LANES)
    ) u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_values  (values),
        .i_hits    (hits),
        .i_restart (s_axis_tuser[0]),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_beat    (beat)
    );

    assign m_axis_tdata = {beat.position, beat.value};
    assign m_axis_tlast = beat.last;

endmodule

[hdl/rsc_checker.sv]
// ----------------------------------------------------------------------------
// Range select and compress checker
// Watches the master side: beats hold under stall, the output is quiet
// after reset, and positions step by one within a group.
// ----------------------------------------------------------------------------
`include "range_select_compress_unit_macros.svh"

module rsc_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    // Fields from bit 0: kept_value (64 bits), out_position (32 bits).
    input logic [rsc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                           m_axis_tlast
);

    logic                        r_seen;
    logic                        r_prev_last;
    logic [rsc_pkg::POS_W-1:0]   r_prev_pos;
    logic                        out_beat;

    assign out_beat = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (out_beat) begin
            r_seen <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_beat) begin
            r_prev_last <= m_axis_tlast;
            r_prev_pos  <= m_axis_tdata[rsc_pkg::OUT_DATA_W-1:rsc_pkg::VALUE_W];
        end
    end

    `RSC_ASSERT_NEXT(a_valid_holds, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `RSC_ASSERT_NEXT(a_beat_holds, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tlast))
    `RSC_ASSERT_RAW(a_quiet_after_reset, i_clk, !i_rst_n, !m_axis_tvalid)
    `RSC_ASSERT_NOW(a_position_steps, i_clk, i_rst_n, out_beat && r_seen && !r_prev_last, m_axis_tdata[rsc_pkg::OUT_DATA_W-1:rsc_pkg::VALUE_W] == r_prev_pos + 32'd1)

endmodule

bind range_select_compress_unit rsc_checker u_rsc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

[dv/range_select_compress_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Range select and compress unit testbench
// Sends groups of eight 64-bit values under a series of bound settings and
// checks every kept value, its compacted position and tlast against an
// in-bench prediction. The run opens with a table of hand-made groups and
// then moves to random phases with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module range_select_compress_unit_tb;

    import rsc_pkg::*;

    localparam int LANES        = 8;
    localparam int DRAIN_CYCLES = 16;
    localparam int STALL_LIMIT  = 2000;
    localparam int GAP_MAX      = 16;
    localparam int PHASE_ITEMS  = 75;
    localparam int EMPTY_ITEMS  = 30;
    localparam int SHOWN_ERRORS = 10;

    typedef logic [VALUE_W-1:0] t_group [LANES];

    typedef enum logic [1:0] {
        ROW_GROUP,
        ROW_TYPED,
        ROW_BOUNDS
    } t_row_kind;

    typedef enum logic [2:0] {
        BOUNDS_RESET,
        BOUNDS_FULL,
        BOUNDS_NARROW,
        BOUNDS_WIDE,
        BOUNDS_EMPTY,
        BOUNDS_LOW
    } t_bound_mode;

    typedef struct {
        t_row_kind          kind;
        t_group             grp;
        logic               restart;
        logic [LANES-1:0]   hit_mask;
        logic [POS_W-1:0]   first_pos;
        logic [BOUND_W-1:0] lo;
        logic [BOUND_W-1:0] hi;
    } t_row;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [APB_ADDR_W-1:0]       paddr;
    logic [APB_DATA_W-1:0]       pwdata;
    logic [APB_DATA_W-1:0]       prdata;
    logic                        pready;
    logic                        s_axis_tvalid;
    logic                        s_axis_tready;
    // Fields from bit 0: lane_0, lane_1, ... lane_7, 64 bits each.
    logic [LANES*VALUE_W-1:0]    s_axis_tdata;
    // Fields from bit 0: restart.
    logic [0:0]                  s_axis_tuser;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready;
    // Fields from bit 0: kept_value (64 bits), out_position (32 bits).
    logic [OUT_DATA_W-1:0]       m_axis_tdata;
    logic                        m_axis_tlast;

    // Predictor state: the bounds in force and the next compacted position.
    logic [BOUND_W-1:0] lo_limit;
    logic [BOUND_W-1:0] hi_limit;
    logic [POS_W-1:0]   next_pos;

    t_beat  awaited_hits [$];
    t_row   directed_rows [$];
    int     fail_count;
    int     groups_sent;
    int     hits_checked;
    int     bound_settings;
    int     idle_cycles;
    logic   tx_quiet;
    logic   rx_quiet;

    range_select_compress_unit #(
        .LANES (LANES)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic void note_mismatch(input string msg);
        fail_count++;
        if (fail_count <= SHOWN_ERRORS) begin
            $display("%0t: mismatch: %s", $realtime, msg);
        end
    endfunction

    // Works out the beats that one group produces and advances the position.
    function automatic int select_in_range(input t_group grp, input logic restart,
                                           output t_beat hits [LANES]);
        int n;
        n = 0;
        if (restart) begin
            next_pos = '0;
        end
        for (int i = 0; i < LANES; i++) begin
            if (grp[i] > {32'd0, lo_limit} && grp[i] < {32'd0, hi_limit}) begin
                hits[n].value    = grp[i];
                hits[n].position = next_pos;
                hits[n].last     = 1'b0;
                next_pos         = next_pos + 1'b1;
                n++;
            end
        end
        if (n > 0) begin
            hits[n-1].last = 1'b1;
        end
        return n;
    endfunction

    function automatic logic [VALUE_W-1:0] pick_lane();
        logic [VALUE_W-1:0] lo64;
        logic [VALUE_W-1:0] hi64;
        logic [VALUE_W-1:0] v;
        lo64 = {32'd0, lo_limit};
        hi64 = {32'd0, hi_limit};
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                if (hi64 > lo64 + 1) begin
                    v = lo64 + 1 + ({$urandom, $urandom} % (hi64 - lo64 - 1));
                end else begin
                    v = {32'd0, $urandom};
                end
            end
            5: v = lo64 + $urandom_range(0, 1);
            6: v = hi64 - $urandom_range(0, 1);
            7: v = {$urandom, $urandom};
            // Upper half set but the low word in range: must not be kept.
            8: v = {$urandom | 32'd1, lo_limit + 32'd1};
            default: v = {32'd0, $urandom};
        endcase
        return v;
    endfunction

    function automatic void add_group(input t_row_kind kind, input t_group grp,
                                      input logic restart, input logic [LANES-1:0] mask,
                                      input logic [POS_W-1:0] first);
        t_row r;
        r.kind      = kind;
        r.grp       = grp;
        r.restart   = restart;
        r.hit_mask  = mask;
        r.first_pos = first;
        r.lo        = '0;
        r.hi        = '0;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_bounds(input logic [BOUND_W-1:0] lo,
                                       input logic [BOUND_W-1:0] hi);
        t_row r;
        r.kind      = ROW_BOUNDS;
        r.restart   = 1'b0;
        r.hit_mask  = '0;
        r.first_pos = '0;
        r.lo        = lo;
        r.hi        = hi;
        for (int i = 0; i < LANES; i++) begin
            r.grp[i] = '0;
        end
        directed_rows.push_back(r);
    endfunction

    // Called at a rising edge; returns at the edge where the group is taken.
    task automatic send_group(input t_group grp, input logic restart, input logic typed,
                              input logic [LANES-1:0] mask, input logic [POS_W-1:0] first);
        logic [LANES*VALUE_W-1:0] packed_lanes;
        t_beat                    hits [LANES];
        int                       n;
        int                       gap;
        logic                     taken;
        for (int i = 0; i < LANES; i++) begin
            packed_lanes[i*VALUE_W +: VALUE_W] = grp[i];
        end
        if ($urandom_range(0, 19) == 0) begin
            tx_quiet = !tx_quiet;
        end
        gap = tx_quiet ? 0 : $urandom_range(0, GAP_MAX);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= packed_lanes;
        s_axis_tuser  <= restart;
        do begin
            @(negedge i_clk);
            taken = (s_axis_tready === 1'b1);
            @(posedge i_clk);
        end while (!taken);
        groups_sent++;
        n = select_in_range(grp, restart, hits);
        if (typed) begin
            // The hand-written expectation stands in for the prediction.
            n = 0;
            for (int i = 0; i < LANES; i++) begin
                if (mask[i]) begin
                    hits[n].value    = grp[i];
                    hits[n].position = first + n;
                    hits[n].last     = 1'b0;
                    n++;
                end
            end
            if (n > 0) begin
                hits[n-1].last = 1'b1;
            end
        end
        for (int i = 0; i < n; i++) begin
            awaited_hits.push_back(hits[i]);
        end
    endtask

    task automatic apb_access(input logic write, input t_reg_idx idx,
                              input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        logic done;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(negedge i_clk);
            done  = pready;
            rdata = prdata;
            @(posedge i_clk);
        end while (!done);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Waits for the block to fall idle, then writes and reads back both bounds.
    task automatic set_bounds(input logic [BOUND_W-1:0] lo, input logic [BOUND_W-1:0] hi);
        logic [APB_DATA_W-1:0] rd;
        s_axis_tvalid <= 1'b0;
        wait (awaited_hits.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        apb_access(1'b1, REG_LOWER, lo, rd);
        apb_access(1'b1, REG_UPPER, hi, rd);
        apb_access(1'b0, REG_LOWER, '0, rd);
        if (rd !== lo) begin
            note_mismatch($sformatf("lower bound read %h, written %h", rd, lo));
        end
        apb_access(1'b0, REG_UPPER, '0, rd);
        if (rd !== hi) begin
            note_mismatch($sformatf("upper bound read %h, written %h", rd, hi));
        end
        lo_limit = lo;
        hi_limit = hi;
        bound_settings++;
    endtask

    // Receiver: a random stall before each beat, with stretches of none.
    initial begin
        int   stall;
        logic took;
        m_axis_tready <= 1'b0;
        rx_quiet = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 24) == 0) begin
                rx_quiet = !rx_quiet;
            end
            stall = rx_quiet ? 0 : $urandom_range(0, GAP_MAX);
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do begin
                @(negedge i_clk);
                took = (m_axis_tvalid === 1'b1);
                @(posedge i_clk);
            end while (!took);
        end
    end

    // Outputs are sampled mid-cycle, where they hold the values seen at the next edge.
    always @(negedge i_clk) begin
        t_beat want;
        logic  s_beat;
        logic  m_beat;
        s_beat = (s_axis_tvalid === 1'b1) && (s_axis_tready === 1'b1);
        m_beat = (m_axis_tvalid === 1'b1) && (m_axis_tready === 1'b1);
        if (i_rst_n === 1'b1) begin
            idle_cycles = (s_beat || m_beat) ? 0 : idle_cycles + 1;
            if (m_beat) begin
                hits_checked++;
                if (awaited_hits.size() == 0) begin
                    note_mismatch($sformatf("unexpected beat value %h position %h",
                                            m_axis_tdata[VALUE_W-1:0],
                                            m_axis_tdata[OUT_DATA_W-1:VALUE_W]));
                end else begin
                    want = awaited_hits.pop_front();
                    if (m_axis_tdata[VALUE_W-1:0] !== want.value) begin
                        note_mismatch($sformatf("kept value %h, expected %h",
                                                m_axis_tdata[VALUE_W-1:0], want.value));
                    end
                    if (m_axis_tdata[OUT_DATA_W-1:VALUE_W] !== want.position) begin
                        note_mismatch($sformatf("position %h, expected %h",
                                                m_axis_tdata[OUT_DATA_W-1:VALUE_W],
                                                want.position));
                    end
                    if (m_axis_tlast !== want.last) begin
                        note_mismatch($sformatf("tlast %b, expected %b at position %h",
                                                m_axis_tlast, want.last, want.position));
                    end
                end
            end
        end
    end

    initial begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("Watchdog: no beat for %0d cycles, %0d values still awaited.",
                 STALL_LIMIT, awaited_hits.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        t_bound_mode           plan [7];
        t_group                grp;
        t_row                  r;
        logic [BOUND_W-1:0]    a;
        logic [BOUND_W-1:0]    b;
        int                    items;

        i_rst_n       <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        fail_count     = 0;
        groups_sent    = 0;
        hits_checked   = 0;
        bound_settings = 0;
        idle_cycles    = 0;
        tx_quiet       = 1'b0;
        lo_limit       = LOWER_RESET;
        hi_limit       = UPPER_RESET;
        next_pos       = '0;

        // Reset bounds 5000 and 10000: both limits exclusive, compared on 64 bits.
        add_group(ROW_TYPED, '{64'd5000, 64'd5001, 64'd9999, 64'd10000, 64'd0,
                  64'hFFFF_FFFF_FFFF_FFFF, 64'd7000, 64'h0000_0001_0000_1B58},
                  1'b0, 8'b0100_0110, 32'd0);
        add_group(ROW_TYPED, '{64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0},
                  1'b0, 8'b0000_0000, 32'd0);
        add_group(ROW_TYPED, '{64'd5001, 64'd5002, 64'd5003, 64'd5004, 64'd5005,
                  64'd5006, 64'd5007, 64'd5008}, 1'b1, 8'b1111_1111, 32'd0);
        // A restart on a group without hits must still clear the position.
        add_group(ROW_TYPED, '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                  64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                  64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF},
                  1'b1, 8'b0000_0000, 32'd0);
        add_group(ROW_TYPED, '{64'd6000, 64'd6001, 64'd6002, 64'd6003, 64'd6004,
                  64'd6005, 64'd6006, 64'd6007}, 1'b0, 8'b1111_1111, 32'd0);
        add_group(ROW_GROUP, '{64'hFFFF_FFFF_0000_1F40, 64'h8000_0000_0000_1770,
                  64'h0000_0001_0000_1771, 64'd7777, 64'd5002, 64'd0, 64'd9998, 64'd12345},
                  1'b0, '0, '0);
        add_bounds(32'h0000_0000, 32'hFFFF_FFFF);
        add_group(ROW_TYPED, '{64'd0, 64'd1, 64'hFFFF_FFFE, 64'hFFFF_FFFF,
                  64'h0000_0001_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 64'h5555_5555_5555_5555,
                  64'hAAAA_AAAA}, 1'b1, 8'b1000_0110, 32'd0);
        add_group(ROW_GROUP, '{64'h0123_4567_89AB_CDEF, 64'hDEAD_BEEF, 64'h1234_5678,
                  64'h7FFF_FFFF, 64'h8000_0000, 64'd2, 64'hFFFF_FFFF_0000_0001, 64'd42},
                  1'b0, '0, '0);
        // Empty range: lower equals upper minus one.
        add_bounds(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        add_group(ROW_TYPED, '{64'hFFFF_FFFE, 64'hFFFF_FFFF, 64'd0, 64'd1,
                  64'h0000_0001_FFFF_FFFF, 64'd7000, 64'hFFFF_FFFF_FFFF_FFFF, 64'd5000},
                  1'b0, 8'b0000_0000, 32'd0);
        add_bounds(32'hFFFF_FFFF, 32'h0000_0000);
        add_group(ROW_TYPED, '{64'd0, 64'd1, 64'd7000, 64'hFFFF_FFFF, 64'hFFFF_FFFE,
                  64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'd12},
                  1'b1, 8'b0000_0000, 32'd0);
        add_bounds(32'd1234, 32'd1234);
        add_group(ROW_TYPED, '{64'd1233, 64'd1234, 64'd1235, 64'd0,
                  64'hFFFF_FFFF_FFFF_FFFF, 64'd5000, 64'd1234, 64'd1234},
                  1'b0, 8'b0000_0000, 32'd0);
        // Only one value fits between the bounds.
        add_bounds(32'd99, 32'd101);
        add_group(ROW_TYPED, '{64'd100, 64'd99, 64'd101, 64'd100, 64'd0, 64'd100,
                  64'h0000_0001_0000_0064, 64'd100}, 1'b1, 8'b1010_1001, 32'd0);
        add_group(ROW_GROUP, '{64'd100, 64'd100, 64'd7, 64'd100, 64'd100, 64'd100,
                  64'd100, 64'd100}, 1'b0, '0, '0);
        add_bounds(LOWER_RESET, UPPER_RESET);
        add_group(ROW_GROUP, '{64'd5001, 64'd1, 64'd9999, 64'd2, 64'd7500, 64'd3,
                  64'd8000, 64'd10001}, 1'b0, '0, '0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            r = directed_rows[k];
            case (r.kind)
                ROW_BOUNDS: set_bounds(r.lo, r.hi);
                ROW_TYPED:  send_group(r.grp, r.restart, 1'b1, r.hit_mask, r.first_pos);
                default:    send_group(r.grp, r.restart, 1'b0, '0, '0);
            endcase
        end

        plan = '{BOUNDS_WIDE, BOUNDS_NARROW, BOUNDS_FULL, BOUNDS_EMPTY,
                 BOUNDS_LOW, BOUNDS_WIDE, BOUNDS_RESET};
        foreach (plan[p]) begin
            a = $urandom;
            b = $urandom;
            case (plan[p])
                BOUNDS_RESET:  set_bounds(LOWER_RESET, UPPER_RESET);
                BOUNDS_FULL:   set_bounds(32'h0000_0000, 32'hFFFF_FFFF);
                BOUNDS_NARROW: set_bounds(a, a + $urandom_range(2, 300));
                BOUNDS_EMPTY:  set_bounds(a, a + $urandom_range(0, 1));
                BOUNDS_LOW:    set_bounds(32'd0, $urandom_range(2, 64));
                default:       set_bounds((a < b) ? a : b, (a < b) ? b : a);
            endcase
            items = (plan[p] == BOUNDS_EMPTY) ? EMPTY_ITEMS : PHASE_ITEMS;
            for (int n = 0; n < items; n++) begin
                for (int i = 0; i < LANES; i++) begin
                    grp[i] = pick_lane();
                end
                send_group(grp, ($urandom_range(0, 7) == 0), 1'b0, '0, '0);
            end
        end

        s_axis_tvalid <= 1'b0;
        wait (awaited_hits.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d groups under %0d bound settings; %0d kept values checked.",
                 groups_sent, bound_settings, hits_checked);
        $display("Mismatches found: %0d.", fail_count);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
